// ===== hw/rtl/vsl_pkg.sv =====
// shared constants for the vector set-length pipeline
// no dependencies
`timescale 1ns / 1ps
package vsl_pkg;
	localparam int DEF_COMP_WIDTH = 32;
	localparam int MIN_LEN_W      = 31;
	localparam int NUM_AXES       = 3;
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;
endpackage

// ===== hw/rtl/vsl_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on nothing but its parameters
`timescale 1ns / 1ps
module vsl_sqrt #(
	parameter int IN_W = 66,
	parameter int SB_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   radicand,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [IN_W/2-1:0] root,
	output logic [SB_W-1:0]   out_sb
);
	localparam int OUT_W = IN_W / 2;
	localparam int RW    = OUT_W + 2;

	logic              v_s   [0:OUT_W];
	logic [RW-1:0]     rem_s [0:OUT_W];
	logic [OUT_W-1:0]  root_s[0:OUT_W];
	logic [IN_W-1:0]   rad_s [0:OUT_W];
	logic [SB_W-1:0]   sb_s  [0:OUT_W];

	// stage zero is the input beat
	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = radicand;
	assign sb_s[0]   = in_sb;

	for (genvar i = 0; i < OUT_W; i++) begin : g_stage
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic          ge;

		// bring down two radicand bits and try the next root bit
		assign rem_sh = {rem_s[i][RW-3:0], rad_s[i][IN_W-1 -: 2]};
		assign trial  = {root_s[i], 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[i+1] <= {root_s[i][OUT_W-2:0], ge};
			rad_s[i+1]  <= {rad_s[i][IN_W-3:0], 2'b00};
			sb_s[i+1]   <= sb_s[i];
		end
	end

	assign out_valid = v_s[OUT_W];
	assign root      = root_s[OUT_W];
	assign out_sb    = sb_s[OUT_W];
endmodule

// ===== hw/rtl/vsl_div.sv =====
// pipelined restoring divider, three lanes over one shared divisor
// uses vsl_pkg for the lane count
`timescale 1ns / 1ps
module vsl_div
	import vsl_pkg::*;
#(
	parameter int W    = 32,
	parameter int SB_W = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2*W-1:0]  num [NUM_AXES],
	input  logic [W:0]      den,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_valid,
	output logic [W-1:0]    quo [NUM_AXES],
	output logic [W+1:0]    rem [NUM_AXES],
	output logic [W:0]      out_den,
	output logic [SB_W-1:0] out_sb
);
	localparam int RW = W + 2;

	logic            v_s  [0:W];
	logic [W:0]      d_s  [0:W];
	logic [SB_W-1:0] sb_s [0:W];
	logic [RW-1:0]   r_s  [0:W][NUM_AXES];
	logic [W-1:0]    q_s  [0:W][NUM_AXES];
	logic [W-1:0]    n_s  [0:W][NUM_AXES];

	// the upper numerator half is known to be below the divisor
	assign v_s[0]  = in_valid;
	assign d_s[0]  = den;
	assign sb_s[0] = in_sb;
	for (genvar l = 0; l < NUM_AXES; l++) begin : g_init
		assign r_s[0][l] = {2'b00, num[l][2*W-1:W]};
		assign q_s[0][l] = '0;
		assign n_s[0][l] = num[l][W-1:0];
	end

	for (genvar i = 0; i < W; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			d_s[i+1]  <= d_s[i];
			sb_s[i+1] <= sb_s[i];
		end

		for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
			logic [RW-1:0] r_sh;
			logic          ge;

			// shift in one numerator bit, subtract when it fits
			assign r_sh = {r_s[i][l][RW-2:0], n_s[i][l][W-1]};
			assign ge   = (r_sh >= {1'b0, d_s[i]});

			always_ff @(posedge clk) begin
				r_s[i+1][l] <= ge ? (r_sh - {1'b0, d_s[i]}) : r_sh;
				q_s[i+1][l] <= {q_s[i][l][W-2:0], ge};
				n_s[i+1][l] <= {n_s[i][l][W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s[W];
	assign out_den   = d_s[W];
	assign out_sb    = sb_s[W];
	for (genvar l = 0; l < NUM_AXES; l++) begin : g_out
		assign quo[l] = q_s[W][l];
		assign rem[l] = r_s[W][l];
	end
endmodule

// ===== hw/rtl/vector3_set_length.sv =====
// path to result_valid: stages 1-3, square root, stage 4, divider, stages 5-6
// throughput: one vector per cycle; busy stays low, the receiver cannot stall
// the square root takes COMP_WIDTH+1 stages and the divider COMP_WIDTH stages
// reset clears all valid bits and sets min_length to zero
// depends on vsl_pkg, vsl_sqrt and vsl_div
`timescale 1ns / 1ps
module vector3_set_length
	import vsl_pkg::*;
#(
	parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COMP_WIDTH-1:0] x_in,
	input  logic signed [COMP_WIDTH-1:0] y_in,
	input  logic signed [COMP_WIDTH-1:0] z_in,
	input  logic signed [COMP_WIDTH-1:0] target_length,
	output logic                         result_valid,
	output logic signed [COMP_WIDTH-1:0] x_out,
	output logic signed [COMP_WIDTH-1:0] y_out,
	output logic signed [COMP_WIDTH-1:0] z_out,
	output logic                         used_fallback,
	output logic                         saturated,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [MIN_LEN_W-1:0]         cfg_data
);
	localparam int W    = COMP_WIDTH;
	localparam int SQ_W = 2 * W + 2;
	localparam int LW   = W + 1;
	localparam int CW   = (LW > MIN_LEN_W) ? LW : MIN_LEN_W;
	localparam int SB1  = 4 * W + 4;
	localparam int SB2  = W + 8;
	localparam int LAT  = 2 * W + 7;
	localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};

	logic [MIN_LEN_W-1:0] min_length_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= '0;
		end else if (cfg_valid) begin
			min_length_q <= cfg_data;
		end
	end

	// stage 1: split into magnitude and sign
	logic         v_s1;
	logic [W-1:0] m_s1 [NUM_AXES];
	logic         n_s1 [NUM_AXES];
	logic [W-1:0] mt_s1;
	logic         nt_s1;
	logic [W-1:0] comp_in [NUM_AXES];

	assign comp_in[0] = x_in;
	assign comp_in[1] = y_in;
	assign comp_in[2] = z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			n_s1[a] <= comp_in[a][W-1];
			m_s1[a] <= comp_in[a][W-1] ? (W'(0) - comp_in[a]) : comp_in[a];
		end
		nt_s1 <= target_length[W-1];
		mt_s1 <= target_length[W-1] ? (W'(0) - target_length) : target_length;
	end

	// stage 2: squares
	logic             v_s2;
	logic [2*W-1:0]   sq_s2 [NUM_AXES];
	logic [SB1-1:0]   sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			sq_s2[a] <= (2*W)'(m_s1[a]) * (2*W)'(m_s1[a]);
		end
		sb_s2 <= {m_s1[0], m_s1[1], m_s1[2], n_s1[0], n_s1[1], n_s1[2], mt_s1, nt_s1};
	end

	// stage 3: sum of squares
	logic            v_s3;
	logic [SQ_W-1:0] sum_s3;
	logic [SB1-1:0]  sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= SQ_W'(sq_s2[0]) + SQ_W'(sq_s2[1]) + SQ_W'(sq_s2[2]);
		sb_s3  <= sb_s2;
	end

	// length by square root
	logic           sq_valid;
	logic [LW-1:0]  len;
	logic [SB1-1:0] sq_sb;

	vsl_sqrt #(
		.IN_W (SQ_W),
		.SB_W (SB1)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.radicand  (sum_s3),
		.in_sb     (sb_s3),
		.out_valid (sq_valid),
		.root      (len),
		.out_sb    (sq_sb)
	);

	logic [W-1:0] m_r [NUM_AXES];
	logic         n_r [NUM_AXES];
	logic [W-1:0] mt_r;
	logic         nt_r;
	logic         fb_c;
	logic [1:0]   k_c;
	logic         pos_c;

	assign {m_r[0], m_r[1], m_r[2], n_r[0], n_r[1], n_r[2], mt_r, nt_r} = sq_sb;
	assign fb_c = !(CW'(len) > CW'(min_length_q));

	// dominant axis, ties toward x then y
	always_comb begin
		if (m_r[0] >= m_r[1] && m_r[0] >= m_r[2]) begin
			k_c = AXIS_X;
		end else if (m_r[1] >= m_r[2]) begin
			k_c = AXIS_Y;
		end else begin
			k_c = AXIS_Z;
		end
		pos_c = !n_r[k_c] && (m_r[k_c] != '0);
	end

	// stage 4: numerators and fallback decision
	logic           v_s4;
	logic [2*W-1:0] num_s4 [NUM_AXES];
	logic [LW-1:0]  len_s4;
	logic [SB2-1:0] sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			num_s4[a] <= (2*W)'(m_r[a]) * (2*W)'(mt_r);
		end
		len_s4 <= len;
		sb_s4  <= {fb_c, k_c, pos_c, n_r[0] != nt_r, n_r[1] != nt_r, n_r[2] != nt_r,
			mt_r, nt_r};
	end

	// per-lane divide by length
	logic           dv_valid;
	logic [W-1:0]   quo [NUM_AXES];
	logic [W+1:0]   rem [NUM_AXES];
	logic [LW-1:0]  dv_den;
	logic [SB2-1:0] dv_sb;

	vsl_div #(
		.W    (W),
		.SB_W (SB2)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (num_s4),
		.den       (len_s4),
		.in_sb     (sb_s4),
		.out_valid (dv_valid),
		.quo       (quo),
		.rem       (rem),
		.out_den   (dv_den),
		.out_sb    (dv_sb)
	);

	// stage 5: round half away from zero
	logic           v_s5;
	logic [W-1:0]   q_s5 [NUM_AXES];
	logic [SB2-1:0] sb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			q_s5[a] <= quo[a] + W'({rem[a], 1'b0} >= (W+3)'(dv_den));
		end
		sb_s5 <= dv_sb;
	end

	// stage 6: fallback select, saturate and sign
	logic         fb5;
	logic [1:0]   k5;
	logic         pos5;
	logic         ln5 [NUM_AXES];
	logic [W-1:0] mt5;
	logic         nt5;
	logic [W-1:0] res_c [NUM_AXES];
	logic         sat_c;

	assign {fb5, k5, pos5, ln5[0], ln5[1], ln5[2], mt5, nt5} = sb_s5;

	always_comb begin
		logic [W-1:0] mag;
		logic         neg;
		sat_c = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (fb5) begin
				mag = (k5 == 2'(a)) ? mt5 : '0;
				neg = pos5 ? nt5 : !nt5;
			end else begin
				mag = q_s5[a];
				neg = ln5[a];
			end
			if (!neg && mag[W-1]) begin
				mag   = POS_MAX;
				sat_c = 1'b1;
			end
			res_c[a] = neg ? (W'(0) - mag) : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		x_out         <= res_c[0];
		y_out         <= res_c[1];
		z_out         <= res_c[2];
		used_fallback <= fb5;
		saturated     <= sat_c;
	end

`ifndef SYNTH
	// every accepted vector comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT result_valid)
		else $error("result missing after pipeline latency");

	// fallback leaves at most one nonzero component
	a_fb_axis: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && used_fallback |->
		$countones({x_out != '0, y_out != '0, z_out != '0}) <= 1)
		else $error("fallback result has several nonzero components");

	// saturation only clips to the positive limit
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
		(x_out == POS_MAX || y_out == POS_MAX || z_out == POS_MAX))
		else $error("saturated without a clipped component");
`endif
endmodule
